// ===== sv/lfk_pkg.sv =====
// Package for leg forward kinematics: payload types, fixed-point constants,
// CORDIC arctangent table. No dependencies.
`timescale 1ns / 1ps
package lfk_pkg;

    localparam int MAX_STAGES     = 24;
    localparam int DEF_STAGES     = 16;
    localparam int ANG_W          = 34;
    localparam int CW             = 34;
    localparam int LEN_W          = 18;
    localparam int TRIG_W         = 22;
    localparam int ADDR_W         = 5;
    localparam logic signed [ANG_W-1:0] ANG_PI      = 34'sd843314857;
    localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 34'sd421657428;
    localparam logic signed [ANG_W-1:0] ANG_TWO_PI  = 34'sd1686629713;
    localparam logic signed [CW-1:0]    CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [TRIG_W-1:0] TRIG_ONE   = 22'sd1048576;

    localparam logic [1:0] LF_FOOT = 2'd0;
    localparam logic [1:0] LH_FOOT = 2'd1;
    localparam logic [1:0] RF_FOOT = 2'd2;
    localparam logic [1:0] RH_FOOT = 2'd3;

    localparam logic [2:0] REG_LEN_ONE   = 3'd0;
    localparam logic [2:0] REG_LEN_TWO   = 3'd1;
    localparam logic [2:0] REG_LEN_THREE = 3'd2;
    localparam logic [2:0] REG_LEN_FOUR  = 3'd3;
    localparam logic [2:0] REG_LEN_FIVE  = 3'd4;

    typedef struct packed {
        logic [1:0]         leg_code;
        logic signed [15:0] roll_angle;
        logic signed [15:0] hip_pitch_angle;
        logic signed [15:0] knee_pitch_angle;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] rot_xx;
        logic signed [15:0] rot_xy;
        logic signed [15:0] rot_xz;
        logic signed [15:0] rot_yx;
        logic signed [15:0] rot_yy;
        logic signed [15:0] rot_yz;
        logic signed [15:0] rot_zx;
        logic signed [15:0] rot_zy;
        logic signed [15:0] rot_zz;
        logic signed [23:0] foot_x;
        logic signed [23:0] foot_y;
        logic signed [23:0] foot_z;
    } out_item_t;

    // atan(2^-i), units 2^-28 rad
    function automatic logic signed [ANG_W-1:0] atan_entry(input int i);
        logic signed [ANG_W-1:0] t;
        case (i)
            0:  t = 34'sd210828714;
            1:  t = 34'sd124459457;
            2:  t = 34'sd65760959;
            3:  t = 34'sd33381290;
            4:  t = 34'sd16755422;
            5:  t = 34'sd8385879;
            6:  t = 34'sd4193963;
            7:  t = 34'sd2097109;
            8:  t = 34'sd1048571;
            9:  t = 34'sd524287;
            10: t = 34'sd262144;
            11: t = 34'sd131072;
            12: t = 34'sd65536;
            13: t = 34'sd32768;
            14: t = 34'sd16384;
            15: t = 34'sd8192;
            16: t = 34'sd4096;
            17: t = 34'sd2048;
            18: t = 34'sd1024;
            19: t = 34'sd512;
            20: t = 34'sd256;
            21: t = 34'sd128;
            22: t = 34'sd64;
            23: t = 34'sd32;
            default: t = '0;
        endcase
        return t;
    endfunction

endpackage

// ===== sv/leg_forward_kinematics_top.sv =====
// Top level of leg forward kinematics: APB length registers, three CORDIC units,
// multiply stages and output rounding. Depends on lfk_pkg and lfk_cordic.
`timescale 1ns / 1ps
// Accepts one joint set per cycle while the output is not stalled and returns one
// foot pose per item, in order. Each item passes through the angle-scale register,
// range reduction, the CORDIC iterations (CORDIC_STAGES, capped at 24), CORDIC output
// rounding, two multiply stages, a position-sum stage and the rounding/saturation
// output register, which drives m_data and m_valid. The whole pipeline advances
// when the output register is empty or being taken, so a stall holds every item.
// Lengths are written through APB at 4*index and must not change while items fly.
module leg_forward_kinematics_top #(
    parameter int CORDIC_STAGES = lfk_pkg::DEF_STAGES
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                s_valid,
    output logic                s_ready,
    input  lfk_pkg::in_item_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output lfk_pkg::out_item_t  m_data
);
    localparam int N   = (CORDIC_STAGES > lfk_pkg::MAX_STAGES) ?
                         lfk_pkg::MAX_STAGES : CORDIC_STAGES;
    localparam int CL  = N + 2;          // cordic latency
    localparam int DEP = CL + 4;         // total stages before output register
    localparam int LW  = lfk_pkg::LEN_W;
    localparam int TW  = lfk_pkg::TRIG_W;

    logic signed [LW-1:0] len_reg [0:4];

    assign pready = 1'b1;
    wire [2:0] ridx = paddr[4:2];
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 5; k++) len_reg[k] <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (ridx)
                lfk_pkg::REG_LEN_ONE:   len_reg[0] <= pwdata[LW-1:0];
                lfk_pkg::REG_LEN_TWO:   len_reg[1] <= pwdata[LW-1:0];
                lfk_pkg::REG_LEN_THREE: len_reg[2] <= pwdata[LW-1:0];
                lfk_pkg::REG_LEN_FOUR:  len_reg[3] <= pwdata[LW-1:0];
                lfk_pkg::REG_LEN_FIVE:  len_reg[4] <= pwdata[LW-1:0];
                default: ;
            endcase
        end
    end
    always_comb begin
        unique case (ridx)
            lfk_pkg::REG_LEN_ONE:   prdata = 32'(len_reg[0]);
            lfk_pkg::REG_LEN_TWO:   prdata = 32'(len_reg[1]);
            lfk_pkg::REG_LEN_THREE: prdata = 32'(len_reg[2]);
            lfk_pkg::REG_LEN_FOUR:  prdata = 32'(len_reg[3]);
            lfk_pkg::REG_LEN_FIVE:  prdata = 32'(len_reg[4]);
            default:                prdata = '0;
        endcase
    end

    // pipeline advance
    logic adv;
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    logic [DEP-1:0] vld_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) vld_reg <= '0;
        else if (adv) vld_reg <= {vld_reg[DEP-2:0], s_valid};
    end

    // stage 0: scale angles
    logic signed [33:0] a1_reg, a2_reg, a3_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            a1_reg <= {{2{s_data.roll_angle[15]}}, s_data.roll_angle, 16'd0};
            a2_reg <= {{2{s_data.hip_pitch_angle[15]}}, s_data.hip_pitch_angle, 16'd0};
            a3_reg <= {({{2{s_data.hip_pitch_angle[15]}}, s_data.hip_pitch_angle}
                       + {{2{s_data.knee_pitch_angle[15]}}, s_data.knee_pitch_angle}),
                       16'd0};
        end
    end

    // leg code delay line to the multiply stage
    logic [1:0] leg_reg [0:CL];
    always_ff @(posedge aclk) begin
        if (adv) begin
            leg_reg[0] <= s_data.leg_code;
            for (int k = 1; k <= CL; k++) leg_reg[k] <= leg_reg[k-1];
        end
    end

    logic signed [TW-1:0] c1, s1, c2, s2, c, s;
    lfk_cordic #(.STAGES(N)) u_cor1 (.aclk, .en(adv), .angle(a1_reg),
                                     .cos_out(c1), .sin_out(s1));
    lfk_cordic #(.STAGES(N)) u_cor2 (.aclk, .en(adv), .angle(a2_reg),
                                     .cos_out(c2), .sin_out(s2));
    lfk_cordic #(.STAGES(N)) u_cor3 (.aclk, .en(adv), .angle(a3_reg),
                                     .cos_out(c), .sin_out(s));

    wire [1:0] leg = leg_reg[CL];
    wire signed [LW:0] l1 = leg[0] ? -(LW+1)'(len_reg[0]) : (LW+1)'(len_reg[0]);
    wire signed [LW:0] l2 = leg[1] ? -(LW+1)'(len_reg[1]) : (LW+1)'(len_reg[1]);
    wire signed [LW:0] l3 = leg[1] ? -(LW+1)'(len_reg[2]) : (LW+1)'(len_reg[2]);

    // stage M1: products
    logic signed [43:0] p_s1s_reg, p_s1c_reg, p_c1s_reg, p_c1c_reg;
    logic signed [40:0] p4s2_reg, p5s_reg, p4c2_reg, p5c_reg, p3c1_reg, p3s1_reg;
    logic signed [LW:0] l1_reg, l2_reg;
    logic signed [TW-1:0] c1_reg, s1_reg, cm_reg, sm_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            p_s1s_reg <= 44'(s1 * s);
            p_s1c_reg <= 44'(s1 * c);
            p_c1s_reg <= 44'(c1 * s);
            p_c1c_reg <= 44'(c1 * c);
            p4s2_reg  <= 41'(len_reg[3] * s2);
            p5s_reg   <= 41'(len_reg[4] * s);
            p4c2_reg  <= 41'(len_reg[3] * c2);
            p5c_reg   <= 41'(len_reg[4] * c);
            p3c1_reg  <= 41'(l3 * c1);
            p3s1_reg  <= 41'(l3 * s1);
            l1_reg <= l1; l2_reg <= l2;
            c1_reg <= c1; s1_reg <= s1; cm_reg <= c; sm_reg <= s;
        end
    end

    // stage M2: vz products, sums
    logic signed [42:0] vz;
    assign vz = -(43'(p4c2_reg) + 43'(p5c_reg));
    logic signed [64:0] s1vz_reg, c1vz_reg;
    logic signed [63:0] px_reg;
    logic signed [42:0] p3c1d_reg, p3s1d_reg;
    logic signed [LW:0] l2d_reg;
    logic signed [15:0] r_xx_reg, r_xz_reg, r_yx_reg, r_yz_reg;
    logic signed [15:0] r_zx_reg, r_zy_reg, r_zz_reg, r_yy_reg;

    function automatic logic signed [15:0] rnd6(input logic signed [TW-1:0] v);
        logic signed [TW-1:0] t;
        t = (v + TW'(32)) >>> 6;
        return t[15:0];
    endfunction
    function automatic logic signed [15:0] rnd26(input logic signed [43:0] v);
        logic signed [44:0] t;
        t = (45'(v) + 45'(1 << 25)) >>> 26;
        return t[15:0];
    endfunction

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1vz_reg  <= 65'(s1_reg * vz);
            c1vz_reg  <= 65'(c1_reg * vz);
            px_reg    <= (64'(l1_reg) <<< 20) - 64'(p4s2_reg) - 64'(p5s_reg);
            p3c1d_reg <= 43'(p3c1_reg);
            p3s1d_reg <= 43'(p3s1_reg);
            l2d_reg   <= l2_reg;
            r_xx_reg <= rnd6(cm_reg);
            r_xz_reg <= rnd6(sm_reg);
            r_yy_reg <= rnd6(c1_reg);
            r_zy_reg <= rnd6(s1_reg);
            r_yx_reg <= rnd26(p_s1s_reg);
            r_yz_reg <= rnd26(-p_s1c_reg);
            r_zx_reg <= rnd26(-p_c1s_reg);
            r_zz_reg <= rnd26(p_c1c_reg);
        end
    end

    // stage M3: position sums
    logic signed [63:0] py_reg, pz_reg, px2_reg;
    logic signed [15:0] q_xx_reg, q_xz_reg, q_yx_reg, q_yz_reg;
    logic signed [15:0] q_zx_reg, q_zy_reg, q_zz_reg, q_yy_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            py_reg  <= (64'(l2d_reg) <<< 20) + 64'(p3c1d_reg)
                       - 64'((s1vz_reg + 65'(1 << 19)) >>> 20);
            pz_reg  <= 64'(p3s1d_reg) + 64'((c1vz_reg + 65'(1 << 19)) >>> 20);
            px2_reg <= px_reg;
            q_xx_reg <= r_xx_reg; q_xz_reg <= r_xz_reg;
            q_yx_reg <= r_yx_reg; q_yz_reg <= r_yz_reg;
            q_zx_reg <= r_zx_reg; q_zy_reg <= r_zy_reg;
            q_zz_reg <= r_zz_reg; q_yy_reg <= r_yy_reg;
        end
    end

    function automatic logic signed [23:0] sat(input logic signed [63:0] v);
        logic signed [63:0] r;
        r = (v + 64'(1 << 19)) >>> 20;
        if (r > 64'sd8388607)       return 24'sh7fffff;
        else if (r < -64'sd8388608) return 24'sh800000;
        return r[23:0];
    endfunction

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) m_valid <= 1'b0;
        else if (adv) m_valid <= vld_reg[DEP-1];
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            m_data.rot_xx <= q_xx_reg;
            m_data.rot_xy <= '0;
            m_data.rot_xz <= q_xz_reg;
            m_data.rot_yx <= q_yx_reg;
            m_data.rot_yy <= q_yy_reg;
            m_data.rot_yz <= q_yz_reg;
            m_data.rot_zx <= q_zx_reg;
            m_data.rot_zy <= q_zy_reg;
            m_data.rot_zz <= q_zz_reg;
            m_data.foot_x <= sat(px2_reg);
            m_data.foot_y <= sat(py_reg);
            m_data.foot_z <= sat(pz_reg);
        end
    end
endmodule

// ===== sv/lfk_cordic.sv =====
// Pipelined rotation-mode CORDIC: angle in 2^-28 rad to cos/sin in Q1.20.
// Depends on lfk_pkg. One range-reduction stage, STAGES iterations, one output stage.
`timescale 1ns / 1ps
module lfk_cordic #(
    parameter int STAGES = lfk_pkg::DEF_STAGES
) (
    input  logic                                   aclk,
    input  logic                                   en,
    input  logic signed [lfk_pkg::ANG_W-1:0]       angle,
    output logic signed [lfk_pkg::TRIG_W-1:0]      cos_out,
    output logic signed [lfk_pkg::TRIG_W-1:0]      sin_out
);
    localparam int N  = (STAGES > lfk_pkg::MAX_STAGES) ? lfk_pkg::MAX_STAGES : STAGES;
    localparam int AW = lfk_pkg::ANG_W;
    localparam int CW = lfk_pkg::CW;
    localparam int TW = lfk_pkg::TRIG_W;

    // inputs reach +-16 rad: at most three wraps of 2*pi
    logic signed [AW-1:0] a1, a2, ar;
    logic                 neg;
    always_comb begin
        a1 = angle;
        if (a1 > lfk_pkg::ANG_PI + lfk_pkg::ANG_TWO_PI + lfk_pkg::ANG_TWO_PI)
            a1 = a1 - lfk_pkg::ANG_TWO_PI - lfk_pkg::ANG_TWO_PI - lfk_pkg::ANG_TWO_PI;
        else if (a1 > lfk_pkg::ANG_PI + lfk_pkg::ANG_TWO_PI)
            a1 = a1 - lfk_pkg::ANG_TWO_PI - lfk_pkg::ANG_TWO_PI;
        else if (a1 > lfk_pkg::ANG_PI)
            a1 = a1 - lfk_pkg::ANG_TWO_PI;
        else if (a1 < -lfk_pkg::ANG_PI - lfk_pkg::ANG_TWO_PI - lfk_pkg::ANG_TWO_PI)
            a1 = a1 + lfk_pkg::ANG_TWO_PI + lfk_pkg::ANG_TWO_PI + lfk_pkg::ANG_TWO_PI;
        else if (a1 < -lfk_pkg::ANG_PI - lfk_pkg::ANG_TWO_PI)
            a1 = a1 + lfk_pkg::ANG_TWO_PI + lfk_pkg::ANG_TWO_PI;
        else if (a1 < -lfk_pkg::ANG_PI)
            a1 = a1 + lfk_pkg::ANG_TWO_PI;
        a2  = a1;
        neg = 1'b0;
        if (a1 > lfk_pkg::ANG_HALF_PI) begin
            a2 = a1 - lfk_pkg::ANG_PI; neg = 1'b1;
        end else if (a1 < -lfk_pkg::ANG_HALF_PI) begin
            a2 = a1 + lfk_pkg::ANG_PI; neg = 1'b1;
        end
        ar = a2;
    end

    logic signed [CW-1:0] x_reg [0:N];
    logic signed [CW-1:0] y_reg [0:N];
    logic signed [AW-1:0] z_reg [0:N];
    logic                 n_reg [0:N];

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0] <= lfk_pkg::CORDIC_GAIN;
            y_reg[0] <= '0;
            z_reg[0] <= ar;
            n_reg[0] <= neg;
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_it
        always_ff @(posedge aclk) begin
            if (en) begin
                if (!z_reg[i][AW-1]) begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - lfk_pkg::atan_entry(i);
                end else begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + lfk_pkg::atan_entry(i);
                end
                n_reg[i+1] <= n_reg[i];
            end
        end
    end

    function automatic logic signed [TW-1:0] fin(input logic signed [CW-1:0] v,
                                                 input logic n);
        logic signed [CW-1:0] r;
        logic signed [TW-1:0] c;
        r = (v + CW'(512)) >>> 10;
        if (r > CW'(lfk_pkg::TRIG_ONE))       c = lfk_pkg::TRIG_ONE;
        else if (r < -CW'(lfk_pkg::TRIG_ONE)) c = -lfk_pkg::TRIG_ONE;
        else                                  c = r[TW-1:0];
        return n ? -c : c;
    endfunction

    always_ff @(posedge aclk) begin
        if (en) begin
            cos_out <= fin(x_reg[N], n_reg[N]);
            sin_out <= fin(y_reg[N], n_reg[N]);
        end
    end
endmodule

// ===== sv/lfk_checker.sv =====
// Port-level checker for leg_forward_kinematics_top, bound to the top level.
// Depends on lfk_pkg for the payload type.
`timescale 1ns / 1ps
module lfk_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic               pready,
    input lfk_pkg::out_item_t m_data
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed under stall");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");
    a_xy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.rot_xy == 16'sd0)
        else $error("rot_xy nonzero");
    a_pready: assert property (@(posedge aclk) pready)
        else $error("pready low");
endmodule

bind leg_forward_kinematics_top lfk_checker u_lfk_checker (
    .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready, .pready, .m_data
);
